[design/lsh_pkg.sv]
package lsh_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int PEND_W     = COL_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [FW_W-1:0] RESET_WIDTH  = FW_W'(640);
    localparam logic [FH_W-1:0] RESET_HEIGHT = FH_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    // item between the counter stage and the filter stage
    typedef struct packed {
        logic             valid;
        logic             pix;
        logic             prod;
        logic             zero;
        logic             last;
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
    } t_s1;

    // last column index of a row, width clamped to 3..MAX_WIDTH
    function automatic logic [COL_W-1:0] last_col_of(input logic [FW_W-1:0] w);
        logic [31:0] wx;
        wx = 32'(w);
        if (wx < 32'd3) begin
            wx = 32'd3;
        end
        if (wx > 32'(MAX_WIDTH)) begin
            wx = 32'(MAX_WIDTH);
        end
        return COL_W'(wx - 32'd1);
    endfunction

    // last row index of a frame, height clamped to at least 3
    function automatic logic [FH_W-1:0] last_row_of(input logic [FH_W-1:0] h);
        logic [FH_W-1:0] lr;
        if (h < FH_W'(3)) begin
            lr = FH_W'(2);
        end else begin
            lr = h - FH_W'(1);
        end
        return lr;
    endfunction

endpackage

[design/lsh_stream_if.sv]
interface lsh_in_if import lsh_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             drain;

    modport source (output valid, output pixel_in, output drain, input ready);
    modport sink   (input valid, input pixel_in, input drain, output ready);
endinterface

interface lsh_out_if import lsh_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

[design/laplacian_sharpen_3x3_core.sv]
// channel   | dir | handshake     | payload
// ----------+-----+---------------+------------------------------------
// i_px      | in  | valid/ready   | pixel_in[7:0], drain
// o_px      | out | valid/ready   | pixel_out[7:0], frame_last
// i_cfg_*   | in  | write enable  | i_cfg_idx: 0 frame_width, 1 frame_height
//
// one item per clock sustained while o_px does not stall; each item goes through the
// line buffer read register, then the result register
// the line buffers are single-port-write, registered-read rams, one access each per item
// synchronous active-low reset clears counters and valids, buffers are not cleared
// o_px stall holds the filter stage; i_px keeps accepting while that stage can move on
module laplacian_sharpen_3x3_core import lsh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lsh_in_if.sink                i_px,
    lsh_out_if.source             o_px
);

    t_s1              s1;
    logic             s1_go;
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic             we;
    logic [COL_W-1:0] waddr;
    logic [PIX_W-1:0] wdata_above;
    logic [PIX_W-1:0] wdata_center;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] center;

    lsh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_px       (i_px),
        .i_s1_go    (s1_go),
        .o_s1       (s1),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr)
    );

    // row r-2
    lsh_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_above (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata_above),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (above)
    );

    // row r-1
    lsh_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_center (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata_center),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (center)
    );

    lsh_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s1           (s1),
        .i_above        (above),
        .i_center       (center),
        .o_s1_go        (s1_go),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata_above  (wdata_above),
        .o_wdata_center (wdata_center),
        .o_px           (o_px)
    );

endmodule

[design/lsh_ram.sv]
module lsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/lsh_front.sv]
module lsh_front import lsh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lsh_in_if.sink                i_px,
    input  logic                  i_s1_go,
    output t_s1                   o_s1,
    output logic                  o_rd_en,
    output logic [COL_W-1:0]      o_rd_addr
);

    logic [COL_W-1:0]  r_col,      n_col;
    logic [FH_W-1:0]   r_row,      n_row;
    logic [PEND_W-1:0] r_pending,  n_pending;
    logic [COL_W-1:0]  r_last_col, n_last_col;
    logic [FH_W-1:0]   r_last_row, n_last_row;
    t_s1               r_s1,       n_s1;

    logic ready;
    logic accept;
    logic flushing;
    logic pix_item;

    assign ready    = !r_s1.valid || i_s1_go;
    assign accept   = i_px.valid && ready;
    assign flushing = (r_pending != '0);
    assign pix_item = !flushing && !i_px.drain;

    assign i_px.ready = ready;
    assign o_s1       = r_s1;
    assign o_rd_en    = accept && pix_item;
    assign o_rd_addr  = r_col;

    always_comb begin
        n_s1       = r_s1;
        n_col      = r_col;
        n_row      = r_row;
        n_pending  = r_pending;
        n_last_col = r_last_col;
        n_last_row = r_last_row;

        if (ready) begin
            n_s1.valid = accept && (flushing || !i_px.drain);
            n_s1.pixel = i_px.pixel_in;
            n_s1.col   = r_col;
            if (flushing) begin
                n_s1.pix  = 1'b0;
                n_s1.prod = 1'b1;
                n_s1.zero = 1'b1;
                n_s1.last = (r_pending == PEND_W'(1));
            end else begin
                n_s1.pix  = 1'b1;
                // column zero finishes the right border pixel two rows up
                n_s1.prod = (r_col == '0) ? (r_row >= FH_W'(2)) : (r_row != '0);
                n_s1.zero = (r_col == '0) || (r_col == COL_W'(1)) || (r_row == FH_W'(1));
                n_s1.last = 1'b0;
            end
        end

        if (accept) begin
            if (flushing) begin
                n_pending = r_pending - PEND_W'(1);
            end else if (!i_px.drain) begin
                if (r_col == r_last_col) begin
                    n_col = '0;
                    if (r_row == r_last_row) begin
                        n_row     = '0;
                        n_pending = PEND_W'(r_last_col) + PEND_W'(2);
                    end else begin
                        n_row = r_row + FH_W'(1);
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
        end

        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH: begin
                    n_last_col = last_col_of(i_cfg_data[FW_W-1:0]);
                end
                CFG_FRAME_HEIGHT: begin
                    n_last_row = last_row_of(i_cfg_data[FH_W-1:0]);
                end
                default: begin
                end
            endcase
            n_col     = '0;
            n_row     = '0;
            n_pending = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_pending  <= '0;
            r_last_col <= last_col_of(RESET_WIDTH);
            r_last_row <= last_row_of(RESET_HEIGHT);
            r_s1       <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_pending  <= n_pending;
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
            r_s1       <= n_s1;
        end
    end

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_last_col)
        else $error("column counter beyond row end");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PEND_W'(r_last_col) + PEND_W'(2))
        else $error("flush count beyond width plus one");

    a_flush_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && flushing && !i_cfg_we |=> !r_s1.pix)
        else $error("pixel item issued while flushing");

endmodule

[design/lsh_back.sv]
module lsh_back import lsh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_s1              i_s1,
    input  logic [PIX_W-1:0] i_above,
    input  logic [PIX_W-1:0] i_center,
    output logic             o_s1_go,
    output logic             o_we,
    output logic [COL_W-1:0] o_waddr,
    output logic [PIX_W-1:0] o_wdata_above,
    output logic [PIX_W-1:0] o_wdata_center,
    lsh_out_if.source        o_px
);

    // window taps: above, left, center, below
    logic [PIX_W-1:0] r_tap0, r_tap1, r_tap2, r_tap3;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_last;

    logic                     go;
    logic                     fire;
    logic [PIX_W+2:0]         five_c;
    logic [PIX_W+1:0]         nsum;
    logic signed [PIX_W+3:0]  v;
    logic [PIX_W-1:0]         sat;

    assign go   = !r_out_valid || o_px.ready;
    assign fire = i_s1.valid && go;

    assign o_s1_go        = go;
    assign o_we           = fire && i_s1.pix;
    assign o_waddr        = i_s1.col;
    assign o_wdata_above  = i_center;
    assign o_wdata_center = i_s1.pixel;

    always_comb begin
        five_c = {1'b0, r_tap2, 2'b00} + (PIX_W+3)'(r_tap2);
        nsum   = (PIX_W+2)'(r_tap1) + (PIX_W+2)'(i_center)
               + (PIX_W+2)'(r_tap0) + (PIX_W+2)'(r_tap3);
        v      = $signed({1'b0, five_c}) - $signed({2'b00, nsum});
        if (v < 0) begin
            sat = '0;
        end else if (v > (PIX_W+4)'(255)) begin
            sat = '1;
        end else begin
            sat = v[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_we) begin
            r_tap1 <= r_tap2;
            r_tap2 <= i_center;
            r_tap0 <= i_above;
            r_tap3 <= i_s1.pixel;
        end
        if (go) begin
            r_out_pixel <= i_s1.zero ? '0 : sat;
            r_out_last  <= i_s1.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= fire && i_s1.prod;
        end
    end

    assign o_px.valid      = r_out_valid;
    assign o_px.pixel_out  = r_out_pixel;
    assign o_px.frame_last = r_out_last;

    a_last_is_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_px.valid && o_px.frame_last |-> o_px.pixel_out == '0)
        else $error("frame end item carries a nonzero pixel");

    a_flush_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s1.valid && !i_s1.pix |-> i_s1.zero && i_s1.prod)
        else $error("flush item not a zero result");

    a_last_only_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s1.valid && i_s1.pix |-> !i_s1.last)
        else $error("pixel item marked as frame end");

endmodule
